FILE: hdl/scg_pkg.sv
`timescale 1ns / 1ps

package scg_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned IDX_W      = 4;   // one store index, one nibble of combo_indices
  localparam int unsigned PICK_W     = 4;   // pick_count register
  localparam int unsigned CNT_W      = 5;   // loaded count, holds up to 16
  localparam int unsigned POS_W      = 3;   // position of a pick cell, up to 8 cells
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned PICK_LIMIT = 8;   // byte lanes of combo_symbols
  localparam int unsigned COMBO_SYM_W = SYM_W * PICK_LIMIT;
  localparam int unsigned COMBO_IDX_W = IDX_W * PICK_LIMIT;

  localparam logic [PICK_W-1:0] PICK_RESET = PICK_W'(4);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_NEXT  = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  // Shared control for the row of pick cells.
  typedef struct packed {
    logic              restart;  // reload position values
    logic              advance;  // step to the next combination
    logic [PICK_W-1:0] k;        // effective pick count, 1..MAX_PICK
    logic [CNT_W-1:0]  n;        // loaded symbol count
  } pick_ctrl_t;

  // Shared control for the row of store cells.
  typedef struct packed {
    logic             load;      // insert sym this cycle
    logic [SYM_W-1:0] sym;
  } store_ctrl_t;

endpackage

FILE: hdl/scg_if.sv
`timescale 1ns / 1ps

interface scg_req_if;
  import scg_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [SYM_W-1:0] symbol;
  modport source (output valid, command, symbol, input ready);
  modport sink (input valid, command, symbol, output ready);
endinterface

interface scg_rsp_if;
  import scg_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [COMBO_SYM_W-1:0] combo_symbols;
  logic [COMBO_IDX_W-1:0] combo_indices;
  logic [STAT_W-1:0]      status;
  modport source (output valid, combo_symbols, combo_indices, status, input ready);
  modport sink (input valid, combo_symbols, combo_indices, status, output ready);
endinterface

interface scg_cfg_if;
  import scg_pkg::*;
  logic              valid;
  logic              ready;
  logic [PICK_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hdl/scg_store_cell.sv
`timescale 1ns / 1ps

module scg_store_cell
  import scg_pkg::*;
(
  input  logic             clk,
  input  store_ctrl_t      ctrl,
  input  logic             occupied,  // this slot holds a loaded symbol
  input  logic             tail,      // this slot is the first free one
  input  logic [SYM_W-1:0] left_val,
  input  logic             left_gt,
  output logic [SYM_W-1:0] val,
  output logic             gt
);

  logic [SYM_W-1:0] val_next;

  // Occupied slots above the new symbol form a suffix; they move right by one.
  assign gt = occupied && (val > ctrl.sym);

  always_comb begin
    val_next = val;
    if (ctrl.load && (occupied || tail)) begin
      if (left_gt) begin
        val_next = left_val;
      end else if (gt || tail) begin
        val_next = ctrl.sym;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: hdl/scg_pick_cell.sv
`timescale 1ns / 1ps

module scg_pick_cell
  import scg_pkg::*;
(
  input  logic             clk,
  input  pick_ctrl_t       ctrl,
  input  logic [POS_W-1:0] pos,         // this cell's position, also its restart value
  input  logic             right_found, // some cell to the right can still move
  input  logic             left_moved,  // left neighbor takes a new value
  input  logic [IDX_W-1:0] left_new,
  output logic             found,
  output logic             moved,
  output logic [IDX_W-1:0] idx_new,
  output logic [IDX_W-1:0] idx
);

  logic       active;
  logic       can;
  logic       pivot;
  logic [5:0] lhs;
  logic [5:0] rhs;

  // idx < n - k + pos, rearranged to stay unsigned
  assign active = {1'b0, pos} < ctrl.k;
  assign lhs    = {2'b00, idx} + {2'b00, ctrl.k};
  assign rhs    = {1'b0, ctrl.n} + {3'b000, pos};
  assign can    = active && (lhs < rhs);
  assign found  = right_found || can;
  assign pivot  = can && !right_found;
  assign moved  = pivot || left_moved;

  always_comb begin
    idx_new = idx;
    if (pivot) begin
      idx_new = idx + IDX_W'(1);
    end else if (left_moved) begin
      idx_new = left_new + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.restart) begin
      idx <= IDX_W'(pos);
    end else if (ctrl.advance) begin
      idx <= idx_new;
    end
  end

endmodule

FILE: hdl/sorted_combination_generator.sv
`timescale 1ns / 1ps

// Sorted combination generator.
// req carries beats of {command, symbol}: clear empties the store, load inserts
// symbol in ascending unsigned order (equal symbols stay in arrival order),
// next returns the current pick_count-of-loaded combination and steps to the
// lexicographically following one. Every request gives exactly one rsp beat
// {combo_symbols, combo_indices, status}; byte / nibble p holds position p.
// A load into a full store is dropped with status 1; next with nothing left
// answers status 2. Any load, clear or cfg write restarts the enumeration.
// cfg carries the pick_count register (0 reads as 1, above MAX_PICK as
// MAX_PICK); write it only while the block is idle.
// Timing: a request is taken and its response is registered, so the response
// shows in the cycle after the accept, and one request is accepted per cycle
// unless stalled. req.ready drops only while a response waits and rsp.ready
// is low; a stalled response holds. The insertion and the advance each finish
// in one pass through the chains of store cells and pick cells.
// Reset (rst, synchronous) empties the store, sets pick_count to 4 and
// restarts the enumeration; no clearing pass is needed.
module sorted_combination_generator
  import scg_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned MAX_PICK    = 8
) (
  input  logic            clk,
  input  logic            rst,
  scg_req_if.sink         req,
  scg_rsp_if.source       rsp,
  scg_cfg_if.sink         cfg
);

  localparam int unsigned SW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  // Control state
  logic [CNT_W-1:0]  count;
  logic [PICK_W-1:0] pick_count;
  logic              done;

  // Response register
  logic                   rsp_valid;
  logic [COMBO_SYM_W-1:0] syms;
  logic [COMBO_IDX_W-1:0] idxs;
  logic [STAT_W-1:0]      status;

  logic                   req_fire;
  logic                   cfg_fire;
  logic [PICK_W-1:0]      k_eff;
  logic                   full;
  logic                   restart;
  logic                   advance;
  logic                   none_left;
  logic [COMBO_SYM_W-1:0] syms_next;
  logic [COMBO_IDX_W-1:0] idxs_next;
  logic [STAT_W-1:0]      status_next;

  store_ctrl_t store_ctrl;
  pick_ctrl_t  pick_ctrl;

  // Chain wires: element i feeds cell i of the store row from the left,
  // pick chains run both ways.
  logic [SYM_W-1:0] st_val [MAX_SYMBOLS+1];
  logic             st_gt  [MAX_SYMBOLS+1];
  logic             pk_found [MAX_PICK+1];
  logic             pk_moved [MAX_PICK+1];
  logic [IDX_W-1:0] pk_new   [MAX_PICK+1];
  logic [IDX_W-1:0] pk_idx   [MAX_PICK];

  assign req_fire  = req.valid && req.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign req.ready = !rsp_valid || rsp.ready;
  assign cfg.ready = 1'b1;

  // Clamp the pick count to 1..MAX_PICK
  always_comb begin
    if (pick_count == '0) begin
      k_eff = PICK_W'(1);
    end else if (pick_count > PICK_W'(MAX_PICK)) begin
      k_eff = PICK_W'(MAX_PICK);
    end else begin
      k_eff = pick_count;
    end
  end

  assign full      = count >= CNT_W'(MAX_SYMBOLS);
  assign none_left = ({1'b0, k_eff} > count) || done;

  // Decode the accepted request
  always_comb begin
    restart     = 1'b0;
    advance     = 1'b0;
    store_ctrl  = '{load: 1'b0, sym: req.symbol};
    status_next = ST_OK;
    if (req_fire) begin
      case (cmd_t'(req.command))
        CMD_CLEAR: begin
          restart = 1'b1;
        end
        CMD_LOAD: begin
          restart = 1'b1;
          if (full) begin
            status_next = ST_FULL;
          end else begin
            store_ctrl.load = 1'b1;
          end
        end
        CMD_NEXT: begin
          if (none_left) begin
            status_next = ST_NONE;
          end else begin
            advance = 1'b1;
          end
        end
        default: begin
          // unused command: no state change, zero response
        end
      endcase
    end
    if (cfg_fire) begin
      restart = 1'b1;
    end
  end

  assign pick_ctrl = '{restart: rst || restart, advance: advance, k: k_eff, n: count};

  // Row of store cells, kept sorted by shifting right on insertion
  assign st_val[0] = '0;
  assign st_gt[0]  = 1'b0;

  for (genvar i = 0; i < MAX_SYMBOLS; i++) begin : g_store
    scg_store_cell u_cell (
      .clk      (clk),
      .ctrl     (store_ctrl),
      .occupied (CNT_W'(i) < count),
      .tail     (CNT_W'(i) == count),
      .left_val (st_val[i]),
      .left_gt  (st_gt[i]),
      .val      (st_val[i+1]),
      .gt       (st_gt[i+1])
    );
  end

  // Row of pick cells: the rightmost movable cell steps, cells to its right
  // follow as consecutive indices.
  assign pk_found[MAX_PICK] = 1'b0;
  assign pk_moved[0]        = 1'b0;
  assign pk_new[0]          = '0;

  for (genvar p = 0; p < MAX_PICK; p++) begin : g_pick
    scg_pick_cell u_cell (
      .clk         (clk),
      .ctrl        (pick_ctrl),
      .pos         (POS_W'(p)),
      .right_found (pk_found[p+1]),
      .left_moved  (pk_moved[p]),
      .left_new    (pk_new[p]),
      .found       (pk_found[p]),
      .moved       (pk_moved[p+1]),
      .idx_new     (pk_new[p+1]),
      .idx         (pk_idx[p])
    );
  end

  // Gather the current combination; positions at or above k stay zero
  always_comb begin
    syms_next = '0;
    idxs_next = '0;
    if (advance) begin
      for (int p = 0; p < MAX_PICK; p++) begin
        if (POS_W'(p) < k_eff[POS_W-1:0] || k_eff == PICK_W'(PICK_LIMIT)) begin
          syms_next[SYM_W*p +: SYM_W] = st_val[int'(pk_idx[p][SW-1:0]) + 1];
          idxs_next[IDX_W*p +: IDX_W] = pk_idx[p];
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pick_count <= PICK_RESET;
      done       <= 1'b0;
    end else begin
      if (cfg_fire) begin
        pick_count <= cfg.data;
      end
      if (restart) begin
        done <= 1'b0;
      end else if (advance) begin
        done <= !pk_found[0];
      end
      if (req_fire && cmd_t'(req.command) == CMD_CLEAR) begin
        count <= '0;
      end else if (store_ctrl.load) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Response register: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      syms   <= syms_next;
      idxs   <= idxs_next;
      status <= status_next;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.combo_symbols = syms;
  assign rsp.combo_indices = idxs;
  assign rsp.status        = status;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

// Checks the sorted combination generator against a cycle-free shadow of its
// store, its loaded count, its pick positions and its pick_count register.
// Every accepted request beat is run through the shadow, and the predicted
// response beat waits in a queue until the block returns its own.
module tb_top
  import scg_pkg::*;
();

  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned MAX_GAP        = 19;      // longest sender gap / receiver stall
  localparam int unsigned STORE_DEPTH    = 16;      // MAX_SYMBOLS of the block
  localparam int unsigned TOTAL_REQUESTS = 1650;
  localparam int unsigned SETTLE_CYCLES  = 4;       // wait after the final drain for stray beats
  localparam int unsigned CYCLE_LIMIT    = 600000;

  // Command code 3 has no meaning; the block must answer it with zeros.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [COMBO_SYM_W-1:0] symbols;
    logic [COMBO_IDX_W-1:0] indices;
    logic [STAT_W-1:0]      status;
  } combo_beat_t;

  logic clk = 1'b0;
  logic rst;

  scg_req_if req_bus ();
  scg_rsp_if rsp_bus ();
  scg_cfg_if cfg_bus ();

  sorted_combination_generator u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow state: what the block should hold after every accepted beat.
  logic [SYM_W-1:0]  shadow_store [STORE_DEPTH];
  int unsigned       shadow_count;
  logic [IDX_W-1:0]  shadow_pos [PICK_LIMIT];
  bit                shadow_done;
  logic [PICK_W-1:0] shadow_pick;

  combo_beat_t pending_combos [$];

  int unsigned mismatch_count = 0;
  int unsigned request_beats  = 0;
  int unsigned combos_seen    = 0;
  int unsigned drops_seen     = 0;
  int unsigned exhausted_seen = 0;
  int unsigned cycle_count    = 0;

  // Idle knobs: when off, that side runs at full rate.
  bit send_gaps_on   = 1'b1;
  bit recv_stalls_on = 1'b1;

  // Put the pick positions back at 0,1,...,MAX_PICK-1 and reopen the walk.
  function automatic void rewind_positions();
    int p;
    for (p = 0; p < PICK_LIMIT; p++) shadow_pos[p] = IDX_W'(p);
    shadow_done = 1'b0;
  endfunction

  // Apply one request to the shadow and return the response it must produce.
  function automatic combo_beat_t combo_after_request(logic [CMD_W-1:0] cmd,
                                                      logic [SYM_W-1:0] sym);
    combo_beat_t r;
    int unsigned k, n, slot, q;
    int i, j, p;
    bit stepped;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_CLEAR: begin
        shadow_count = 0;
        rewind_positions();
      end
      CMD_LOAD: begin
        if (shadow_count >= STORE_DEPTH) begin
          r.status = ST_FULL;
          drops_seen++;
        end else begin
          // Equal symbols go behind the ones already stored.
          slot = 0;
          while (slot < shadow_count && shadow_store[slot] <= sym) slot++;
          for (j = shadow_count; j > int'(slot); j--) shadow_store[j] = shadow_store[j - 1];
          shadow_store[slot] = sym;
          shadow_count++;
        end
        rewind_positions();
      end
      CMD_NEXT: begin
        k = (shadow_pick == 0) ? 1 :
            ((shadow_pick > PICK_LIMIT) ? PICK_LIMIT : shadow_pick);
        n = shadow_count;
        if (k > n || shadow_done) begin
          r.status = ST_NONE;
          exhausted_seen++;
        end else begin
          for (p = 0; p < int'(k); p++) begin
            r.symbols[SYM_W*p +: SYM_W] = shadow_store[shadow_pos[p]];
            r.indices[IDX_W*p +: IDX_W] = shadow_pos[p];
          end
          combos_seen++;
          // Bump the rightmost position that still has room, then pack the
          // ones to its right directly behind it.
          stepped = 1'b0;
          for (i = k; i > 0 && !stepped; i--) begin
            q = i - 1;
            if (shadow_pos[q] < n - k + q) begin
              shadow_pos[q] = shadow_pos[q] + 1'b1;
              for (j = q + 1; j < int'(k); j++) shadow_pos[j] = shadow_pos[j - 1] + 1'b1;
              stepped = 1'b1;
            end
          end
          if (!stepped) shadow_done = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one request beat. Valid stays high after the beat unless the next call
  // draws a gap or a drain follows, so back-to-back beats never drop valid.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym);
    int unsigned gap;
    gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid   <= 1'b1;
    req_bus.command <= cmd;
    req_bus.symbol  <= sym;
    do @(posedge clk); while (!req_bus.ready);
    pending_combos.push_back(combo_after_request(cmd, sym));
    request_beats++;
  endtask

  // Hold off the sender until every predicted response has come back.
  // Always advances at least one edge, so drops of valid never collide.
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_combos.size() != 0);
  endtask

  // Write pick_count while the block is idle; the walk restarts with it.
  task automatic write_pick(logic [PICK_W-1:0] value);
    drain_results();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    shadow_pick = value;
    rewind_positions();
  endtask

  // Receiver: draw a stall for every beat, then hold ready until one is taken.
  initial begin
    int unsigned stall;
    @(negedge rst);
    forever begin
      stall = recv_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  // Compare each response beat with the oldest prediction, field by field.
  always @(posedge clk) begin
    combo_beat_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_combos.size() == 0) begin
        $error("response beat with no request outstanding: status %0d", rsp_bus.status);
        mismatch_count++;
      end else begin
        want = pending_combos.pop_front();
        if (rsp_bus.combo_symbols !== want.symbols) begin
          $error("combo_symbols: expected %h, got %h", want.symbols, rsp_bus.combo_symbols);
          mismatch_count++;
        end
        if (rsp_bus.combo_indices !== want.indices) begin
          $error("combo_indices: expected %h, got %h", want.indices, rsp_bus.combo_indices);
          mismatch_count++;
        end
        if (rsp_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Next on an empty store finds nothing; the spare command answers zeros.
  task automatic test_empty_store();
    send_request(CMD_NEXT, 8'hA5);
    send_request(CMD_SPARE, 8'h5A);
  endtask

  // Walk every 2-of-4 pick over extreme bytes, run past the end, then show
  // that a load after the walk restarts at the first pick.
  task automatic test_short_walk();
    write_pick(PICK_W'(2));
    send_request(CMD_LOAD, 8'hFF);
    send_request(CMD_LOAD, 8'h00);
    send_request(CMD_LOAD, 8'h80);
    send_request(CMD_LOAD, 8'h7F);
    repeat (7) send_request(CMD_NEXT, 8'h00);
    send_request(CMD_LOAD, 8'h55);
    send_request(CMD_NEXT, 8'hFF);
  endtask

  // pick_count of 0 acts as 1, above MAX_PICK as MAX_PICK; a clear leaves
  // nothing to pick.
  task automatic test_pick_limits();
    write_pick('0);
    send_request(CMD_NEXT, 8'h00);
    send_request(CMD_NEXT, 8'h00);
    write_pick('1);
    send_request(CMD_NEXT, 8'h00);
    write_pick(PICK_W'(1));
    send_request(CMD_CLEAR, 8'hFF);
    send_request(CMD_NEXT, 8'h00);
    write_pick(PICK_RESET);
  endtask

  // Sessions of: maybe a new pick_count, usually a clear, a fill (sometimes
  // past full, sometimes from a narrow range to force duplicates), then a
  // walk of nexts with an occasional stray command mixed in.
  task automatic test_random_sessions();
    int unsigned sel, fill, cap, steps;
    logic [PICK_W-1:0] pick;
    logic [SYM_W-1:0] sym_top;
    while (request_beats < TOTAL_REQUESTS) begin
      send_gaps_on   = ($urandom_range(0, 3) != 0);
      recv_stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 0) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) pick = '0;
        else if (sel == 1) pick = PICK_W'($urandom_range(PICK_LIMIT + 1, (1 << PICK_W) - 1));
        else pick = PICK_W'($urandom_range(1, PICK_LIMIT));
        write_pick(pick);
      end
      if ($urandom_range(0, 7) != 0) send_request(CMD_CLEAR, SYM_W'($urandom));
      fill = ($urandom_range(0, 5) == 0) ? $urandom_range(STORE_DEPTH, STORE_DEPTH + 3)
                                         : $urandom_range(0, 10);
      sym_top = ($urandom_range(0, 2) == 0) ? SYM_W'(3) : '1;
      repeat (fill) send_request(CMD_LOAD, SYM_W'($urandom_range(0, sym_top)));
      cap = $urandom_range(1, 40);
      steps = 0;
      while (!shadow_done && steps < cap) begin
        if ($urandom_range(0, 19) == 0)
          send_request(CMD_W'($urandom_range(CMD_CLEAR, CMD_NEXT)), SYM_W'($urandom));
        else
          send_request(CMD_NEXT, SYM_W'($urandom));
        steps++;
      end
      repeat ($urandom_range(0, 2)) send_request(CMD_NEXT, SYM_W'($urandom));
    end
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    rst             <= 1'b1;
    req_bus.valid   <= 1'b0;
    req_bus.command <= CMD_CLEAR;
    req_bus.symbol  <= '0;
    rsp_bus.ready   <= 1'b0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.data    <= PICK_RESET;
    shadow_count = 0;
    shadow_pick  = PICK_RESET;
    rewind_positions();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_short_walk();
    test_pick_limits();
    test_random_sessions();

    // Drain, then give the block a few more cycles to show any stray beat.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d request beats: %0d combinations walked,", request_beats,
             combos_seen);
    $display("  %0d loads dropped on a full store, %0d nexts with nothing left.",
             drops_seen, exhausted_seen);
    if (mismatch_count == 0 && pending_combos.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/scg_pkg.sv
hdl/scg_if.sv
hdl/scg_store_cell.sv
hdl/scg_pick_cell.sv
hdl/sorted_combination_generator.sv
sim/tb_top.sv
